FILE: rtl/plu_pkg.sv
package plu_pkg;

    localparam int MAX_LEN     = 20;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int RANK_W      = 64;
    localparam int DIGIT_W     = 5;
    localparam int CNT_W       = $clog2(DIGIT_W + 1);
    localparam int FACT_BASE_W = 57;
    localparam int DIV_W       = FACT_BASE_W + DIGIT_W - 1;

    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic load_rank;
        logic start;
    } plu_div_ctrl_t;

    typedef struct packed {
        logic init;
        logic shift;
        len_t idx;
    } plu_cell_ctrl_t;

    function automatic rank_t fact(input len_t idx);
        rank_t f;
        begin
            case (idx)
                5'd0:    f = 64'd1;
                5'd1:    f = 64'd1;
                5'd2:    f = 64'd2;
                5'd3:    f = 64'd6;
                5'd4:    f = 64'd24;
                5'd5:    f = 64'd120;
                5'd6:    f = 64'd720;
                5'd7:    f = 64'd5040;
                5'd8:    f = 64'd40320;
                5'd9:    f = 64'd362880;
                5'd10:   f = 64'd3628800;
                5'd11:   f = 64'd39916800;
                5'd12:   f = 64'd479001600;
                5'd13:   f = 64'd6227020800;
                5'd14:   f = 64'd87178291200;
                5'd15:   f = 64'd1307674368000;
                5'd16:   f = 64'd20922789888000;
                5'd17:   f = 64'd355687428096000;
                5'd18:   f = 64'd6402373705728000;
                5'd19:   f = 64'd121645100408832000;
                5'd20:   f = 64'd2432902008176640000;
                default: f = 64'd0;
            endcase
            return f;
        end
    endfunction

endpackage

FILE: rtl/permutation_unrank_lehmer.sv
// Channel  Handshake              Payload
// cfg      cfg_valid / cfg_ready  perm_length
// in       in_valid / in_ready    rank
// out      out_valid / out_ready  element, position, is_last, rank_error
//
// After a rank transfers, the core runs a range check against n! (n = perm_length,
// saturated to 1..20), then per element five quotient-bit steps of the
// shift-subtract digit unit and an emit step.
// A rank at or above n! gives one error result after the range check.
// rst_n is asynchronous and clears control state; perm_length resets to 1.
// A stalled output holds the core; a new rank transfers while the last result waits.
module permutation_unrank_lehmer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  plu_pkg::len_t  perm_length,
    input  logic           in_valid,
    output logic           in_ready,
    input  plu_pkg::rank_t rank,
    output logic           out_valid,
    input  logic           out_ready,
    output plu_pkg::len_t  element,
    output plu_pkg::len_t  position,
    output logic           is_last,
    output logic           rank_error
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DIV   = 3'b100
    } plu_state_t;

    plu_state_t              state_reg;
    plu_state_t              state_next;
    plu_pkg::len_t           perm_length_reg;
    plu_pkg::len_t           perm_length_next;
    plu_pkg::len_t           n_reg;
    plu_pkg::len_t           n_next;
    plu_pkg::len_t           pos_reg;
    plu_pkg::len_t           pos_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    plu_pkg::len_t           element_reg;
    plu_pkg::len_t           element_next;
    plu_pkg::len_t           position_reg;
    plu_pkg::len_t           position_next;
    logic                    is_last_reg;
    logic                    is_last_next;
    logic                    rank_error_reg;
    logic                    rank_error_next;

    plu_pkg::plu_div_ctrl_t  div_ctrl;
    plu_pkg::plu_cell_ctrl_t cell_ctrl;
    logic                    div_busy;
    plu_pkg::digit_t         digit;
    plu_pkg::rank_t          div_rem;
    plu_pkg::rank_t          base_full;
    plu_pkg::len_t           base_idx;
    plu_pkg::len_t           len_eff;
    plu_pkg::len_t           count;
    plu_pkg::len_t           idx;
    logic                    out_free;
    logic                    load_out;
    logic                    last;
    logic                    too_big;
    plu_pkg::len_t           pool_val [plu_pkg::MAX_LEN];

    always_comb
    begin
        if (perm_length_reg == '0)
        begin
            len_eff = plu_pkg::len_t'(1);
        end
        else if (perm_length_reg > plu_pkg::len_t'(plu_pkg::MAX_LEN))
        begin
            len_eff = plu_pkg::len_t'(plu_pkg::MAX_LEN);
        end
        else
        begin
            len_eff = perm_length_reg;
        end

        perm_length_next = (cfg_valid && cfg_ready) ? perm_length : perm_length_reg;

        out_free = !out_valid_reg || out_ready;
        count    = n_reg - pos_reg;
        idx      = (plu_pkg::len_t'(digit) >= count) ? count - 1'b1 : plu_pkg::len_t'(digit);
        last     = (pos_reg == n_reg - 1'b1);
        too_big  = (div_rem >= plu_pkg::fact(n_reg));
        base_idx = (state_reg == ST_CHECK) ? n_reg - 1'b1
                                           : n_reg - pos_reg - plu_pkg::len_t'(2);
        base_full = plu_pkg::fact(base_idx);

        state_next      = state_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        div_ctrl        = '0;
        cell_ctrl.init  = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.idx   = idx;
        load_out        = 1'b0;
        element_next    = '0;
        position_next   = '0;
        is_last_next    = 1'b1;
        rank_error_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_ctrl.load_rank = 1'b1;
                    cell_ctrl.init     = 1'b1;
                    n_next             = len_eff;
                    pos_next           = '0;
                    state_next         = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (too_big)
                begin
                    if (out_free)
                    begin
                        load_out        = 1'b1;
                        rank_error_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    load_out        = 1'b1;
                    element_next    = pool_val[idx];
                    position_next   = pos_reg;
                    is_last_next    = last;
                    cell_ctrl.shift = 1'b1;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next       = pos_reg + 1'b1;
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            perm_length_reg <= plu_pkg::len_t'(1);
            out_valid_reg   <= 1'b0;
            n_reg           <= plu_pkg::len_t'(1);
            pos_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            perm_length_reg <= perm_length_next;
            out_valid_reg   <= out_valid_next;
            n_reg           <= n_next;
            pos_reg         <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            element_reg    <= element_next;
            position_reg   <= position_next;
            is_last_reg    <= is_last_next;
            rank_error_reg <= rank_error_next;
        end
    end

    plu_digit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .rank  (rank),
        .base  (base_full[plu_pkg::FACT_BASE_W-1:0]),
        .busy  (div_busy),
        .digit (digit),
        .rem   (div_rem)
    );

    for (genvar i = 0; i < plu_pkg::MAX_LEN; i++)
    begin : g_pool
        plu_pkg::len_t right_val;

        if (i == plu_pkg::MAX_LEN - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = pool_val[i+1];
        end

        plu_cell u_cell (
            .clk       (clk),
            .my_index  (plu_pkg::len_t'(i)),
            .ctrl      (cell_ctrl),
            .right_val (right_val),
            .val       (pool_val[i])
        );
    end

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign element    = element_reg;
    assign position   = position_reg;
    assign is_last    = is_last_reg;
    assign rank_error = rank_error_reg;

endmodule

FILE: rtl/plu_cell.sv
module plu_cell (
    input  logic                    clk,
    input  plu_pkg::len_t           my_index,
    input  plu_pkg::plu_cell_ctrl_t ctrl,
    input  plu_pkg::len_t           right_val,
    output plu_pkg::len_t           val
);

    plu_pkg::len_t val_reg;
    plu_pkg::len_t val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.init)
        begin
            val_next = my_index;
        end
        else if (ctrl.shift && (my_index >= ctrl.idx))
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: rtl/plu_digit.sv
module plu_digit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plu_pkg::plu_div_ctrl_t            ctrl,
    input  plu_pkg::rank_t                    rank,
    input  logic [plu_pkg::FACT_BASE_W-1:0]   base,
    output logic                              busy,
    output plu_pkg::digit_t                   digit,
    output plu_pkg::rank_t                    rem
);

    plu_pkg::rank_t                 rem_reg;
    plu_pkg::rank_t                 rem_next;
    logic [plu_pkg::DIV_W-1:0]      div_reg;
    logic [plu_pkg::DIV_W-1:0]      div_next;
    plu_pkg::digit_t                digit_reg;
    plu_pkg::digit_t                digit_next;
    logic [plu_pkg::CNT_W-1:0]      cnt_reg;
    logic [plu_pkg::CNT_W-1:0]      cnt_next;
    logic                           busy_reg;
    logic                           busy_next;
    plu_pkg::rank_t                 div_ext;
    logic                           fits;

    always_comb
    begin
        div_ext = {{(plu_pkg::RANK_W - plu_pkg::DIV_W){1'b0}}, div_reg};
        fits    = (rem_reg >= div_ext);

        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        digit_next = digit_reg;

        if (ctrl.load_rank)
        begin
            rem_next = rank;
        end

        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = plu_pkg::CNT_W'(plu_pkg::DIGIT_W);
            div_next   = {base, {(plu_pkg::DIGIT_W - 1){1'b0}}};
            digit_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next   = cnt_reg - 1'b1;
            busy_next  = (cnt_reg != plu_pkg::CNT_W'(1));
            div_next   = div_reg >> 1;
            digit_next = {digit_reg[plu_pkg::DIGIT_W-2:0], fits};
            if (fits)
            begin
                rem_next = rem_reg - div_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        digit_reg <= digit_next;
    end

    assign busy  = busy_reg;
    assign digit = digit_reg;
    assign rem   = rem_reg;

endmodule

FILE: test/permutation_unrank_lehmer_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [4:0] element;
    logic [4:0] position;
    logic       is_last;
    logic       rank_error;
} perm_slot_t;

class perm_scoreboard;
    longint unsigned fact_of[21];
    perm_slot_t      pending_q[$];
    logic [4:0]      length_reg;
    int              mismatches;
    int              ranks_seen;
    int              overflows;
    int              elements_seen;
    int              settings_seen;

    function new();
        fact_of[0] = 1;
        for (int i = 1; i <= 20; i++)
        begin
            fact_of[i] = fact_of[i-1] * longint'(i);
        end
        length_reg    = 5'd1;
        mismatches    = 0;
        ranks_seen    = 0;
        overflows     = 0;
        elements_seen = 0;
        settings_seen = 0;
    endfunction

    function void set_length(logic [4:0] value);
        length_reg = value;
        settings_seen++;
    endfunction

    function int live_length();
        int n;
        n = int'(length_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > 20)
        begin
            n = 20;
        end
        return n;
    endfunction

    // Expand one rank into its permutation elements.
    function void note_rank(longint unsigned value);
        perm_slot_t      slot;
        logic [4:0]      pool[$];
        longint unsigned left;
        longint unsigned base;
        longint unsigned digit;
        int              n;
        int              idx;
        n = live_length();
        ranks_seen++;
        if (value >= fact_of[n])
        begin
            overflows++;
            slot = '{element: 5'd0, position: 5'd0, is_last: 1'b1, rank_error: 1'b1};
            pending_q.push_back(slot);
            return;
        end
        pool.delete();
        for (int i = 0; i < n; i++)
        begin
            pool.push_back(5'(i));
        end
        left = value;
        for (int pos = 0; pos < n; pos++)
        begin
            base  = fact_of[n - pos - 1];
            digit = left / base;
            if (digit >= longint'(pool.size()))
            begin
                digit = longint'(pool.size() - 1);
            end
            idx = int'(digit);
            slot.element    = pool[idx];
            slot.position   = 5'(pos);
            slot.is_last    = (pos + 1 == n);
            slot.rank_error = 1'b0;
            pending_q.push_back(slot);
            pool.delete(idx);
            left = left % base;
        end
    endfunction

    function void check_result(perm_slot_t got);
        perm_slot_t want;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result: element %0d position %0d last %0d error %0d",
                         got.element, got.position, got.is_last, got.rank_error);
            end
            return;
        end
        want = pending_q.pop_front();
        elements_seen++;
        if (got.element !== want.element || got.position !== want.position ||
            got.is_last !== want.is_last || got.rank_error !== want.rank_error)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: element %0d/%0d position %0d/%0d last %0d/%0d error %0d/%0d",
                         want.element, got.element, want.position, got.position,
                         want.is_last, got.is_last, want.rank_error, got.rank_error);
            end
        end
    endfunction
endclass

module permutation_unrank_lehmer_tb;

    localparam int STALL_LIMIT = 3000;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    plu_pkg::len_t  perm_length;
    logic           in_valid;
    logic           in_ready;
    plu_pkg::rank_t rank;
    logic           out_valid;
    logic           out_ready;
    plu_pkg::len_t  element;
    plu_pkg::len_t  position;
    logic           is_last;
    logic           rank_error;

    bit             steady = 1'b0;
    perm_scoreboard sb = new();

    permutation_unrank_lehmer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .perm_length (perm_length),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rank        (rank),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .element     (element),
        .position    (position),
        .is_last     (is_last),
        .rank_error  (rank_error)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic send_rank(input plu_pkg::rank_t value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rank     <= value;
        do @(posedge clk); while (!(in_valid === 1'b1 && in_ready === 1'b1));
        sb.note_rank(value);
    endtask

    // Drain the pipe, then write the length register.
    task automatic write_length(input logic [4:0] value);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid   <= 1'b1;
        perm_length <= value;
        do @(posedge clk); while (!(cfg_valid === 1'b1 && cfg_ready === 1'b1));
        cfg_valid <= 1'b0;
        sb.set_length(value);
    endtask

    function automatic plu_pkg::rank_t pick_rank();
        longint unsigned lim;
        longint unsigned r;
        int              sel;
        lim = sb.fact_of[sb.live_length()];
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            return r % lim;
        end
        else if (sel == 7)
        begin
            return lim - 1;
        end
        else if (sel == 8)
        begin
            return lim + (r % 8);
        end
        return r;
    endfunction

    initial
    begin
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
        end
    end

    always @(posedge clk)
    begin
        perm_slot_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.element    = element;
            got.position   = position;
            got.is_last    = is_last;
            got.rank_error = rank_error;
            sb.check_result(got);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("permutation_unrank_lehmer regression: fail");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        perm_length <= '0;
        in_valid    <= 1'b0;
        rank        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // length zero saturates to one
        write_length(5'd0);
        send_rank(64'd0);
        send_rank(64'd1);
        send_rank('1);

        write_length(5'd20);
        send_rank(64'd0);
        send_rank(64'd1);
        send_rank(sb.fact_of[20] - 1);
        send_rank(sb.fact_of[20]);
        send_rank('1);

        // lengths above the maximum saturate
        write_length(5'd31);
        send_rank(sb.fact_of[20] - 1);
        send_rank(64'h5555_5555_5555_5555);

        write_length(5'd3);
        for (int i = 0; i <= 6; i++)
        begin
            send_rank(plu_pkg::rank_t'(i));
        end

        write_length(5'd2);
        send_rank(64'd0);
        send_rank(64'd1);
        send_rank(64'd2);

        for (int phase = 0; phase < 10; phase++)
        begin
            write_length(5'($urandom_range(0, 31)));
            steady = ($urandom_range(0, 3) == 0);
            repeat (21) send_rank(pick_rank());
        end

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d ranks (%0d at or above n!) over %0d length settings",
                 sb.ranks_seen, sb.overflows, sb.settings_seen);
        $display("checked %0d result transfers, %0d mismatches",
                 sb.elements_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
        begin
            $display("permutation_unrank_lehmer regression: pass");
        end
        else
        begin
            $display("permutation_unrank_lehmer regression: fail");
        end
        $finish;
    end
endmodule
